@@ src/bark_band_energy_accumulator_macros.svh @@
// Assertion macros used by the bark band energy accumulator checker
`ifndef BARK_BAND_ENERGY_ACCUMULATOR_MACROS_SVH
`define BARK_BAND_ENERGY_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define BBEA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbea assertion failed");

// next-cycle implication
`define BBEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbea assertion failed");

`endif

@@ src/bbea_pkg.sv @@
// Types and constants of the bark band energy accumulator
`timescale 1ns / 1ps

package bbea_pkg;

    localparam int NUM_BANDS     = 24;
    localparam int MAG_WIDTH     = 24;
    localparam int SUM_WIDTH     = 40;
    localparam int FREQ_WIDTH    = 24;
    localparam int SPACING_WIDTH = 15;
    localparam int BAND_WIDTH    = 5;
    localparam int ENERGY_WIDTH  = 40;
    localparam int WEIGHT_WIDTH  = 16;
    localparam int EDGE_WIDTH    = 14;
    localparam int NUM_EDGES     = 26;
    localparam int TOP_REGION    = 25;
    localparam int REGION_WIDTH  = 5;
    localparam int PADDR_WIDTH   = 3;
    localparam int PDATA_WIDTH   = 32;

    localparam logic [SPACING_WIDTH-1:0] SPACING_RESET   = 15'd43;
    localparam logic                     REG_BIN_SPACING = 1'b0;
    localparam logic [BAND_WIDTH-1:0]    LAST_BAND_INDEX = 5'd23;

    localparam logic [EDGE_WIDTH-1:0] EDGE_HZ [NUM_EDGES] = '{
        14'd0,     14'd50,    14'd150,   14'd250,   14'd350,   14'd450,
        14'd570,   14'd700,   14'd840,   14'd1000,  14'd1170,  14'd1370,
        14'd1600,  14'd1850,  14'd2150,  14'd2500,  14'd2900,  14'd3400,
        14'd4000,  14'd4800,  14'd5800,  14'd7000,  14'd8500,  14'd10500,
        14'd13500, 14'd15500
    };

    localparam logic [WEIGHT_WIDTH-1:0] LOUD_Q16 [NUM_BANDS] = '{
        16'd50869, 16'd44918, 16'd43562, 16'd41766, 16'd40993, 16'd40436,
        16'd40233, 16'd40023, 16'd40154, 16'd41478, 16'd41812, 16'd42140,
        16'd40311, 16'd39538, 16'd38758, 16'd38293, 16'd38633, 16'd38974,
        16'd40875, 16'd43929, 16'd45351, 16'd46773, 16'd47297, 16'd47297
    };

    typedef struct packed {
        logic [MAG_WIDTH-1:0] bin_magnitude;
        logic                 last_bin;
    } t_in_word;

    typedef struct packed {
        logic [BAND_WIDTH-1:0]   band_index;
        logic [ENERGY_WIDTH-1:0] band_energy;
        logic                    last_band;
    } t_out_word;

endpackage

@@ src/bark_band_energy_accumulator.sv @@
// Bark band energy accumulator top level
`timescale 1ns / 1ps

// Takes one spectrum bin per cycle and adds it into at most two Bark band sums,
// held in an even-band and an odd-band memory so both updates proceed every
// cycle; each memory keeps two frame copies, and a one-deep write-back bypass
// covers a read that meets the write of the previous bin. A bin is summed in
// stage 2; once a frame's last bin gets there, the 24 weighted sums drain
// through a read, multiply and output register path at one word per cycle
// unless the output stalls, while the next frame already accumulates in the
// other copy. The input stalls only when a frame ends while the copy it hands
// over to still holds sums that have not all been read out, so with no output
// stall frames of 27 bins or more stream at one bin per cycle. After reset the
// sums read as zero at once via per-entry valid bits; no clearing pass runs.
module bark_band_energy_accumulator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bbea_pkg::PADDR_WIDTH-1:0]    paddr,
    input  logic [bbea_pkg::PDATA_WIDTH-1:0]    pwdata,
    output logic [bbea_pkg::PDATA_WIDTH-1:0]    prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    input  bbea_pkg::t_in_word                  i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output bbea_pkg::t_out_word                 o_out_data,
    input  logic                                i_out_stall
);

    localparam int IDX_W      = 4;
    localparam int ADDR_W     = IDX_W + 1;
    localparam int BANK_DEPTH = 1 << ADDR_W;
    localparam int SUM_W      = bbea_pkg::SUM_WIDTH;
    localparam int PROD_W     = SUM_W + bbea_pkg::WEIGHT_WIDTH;
    localparam int FREQ_W     = bbea_pkg::FREQ_WIDTH;
    localparam int REG_BIT    = bbea_pkg::PADDR_WIDTH - 1;

    // configuration
    logic [bbea_pkg::SPACING_WIDTH-1:0] r_spacing;
    logic                               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[REG_BIT] == bbea_pkg::REG_BIN_SPACING);
    assign prdata = (paddr[REG_BIT] == bbea_pkg::REG_BIN_SPACING) ?
                    bbea_pkg::PDATA_WIDTH'(r_spacing) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= bbea_pkg::SPACING_RESET;
        end else if (cfg_wr) begin
            r_spacing <= pwdata[bbea_pkg::SPACING_WIDTH-1:0];
        end
    end

    // input side
    logic              in_acc;
    logic [FREQ_W-1:0] r_freq;
    logic [FREQ_W:0]   freq_sum;
    logic              r_wsel;
    logic [1:0]        r_busy;
    logic [1:0]        n_busy;
    logic [1:0]        r_req;
    logic [1:0]        n_req;

    assign o_in_stall = r_busy[r_wsel];
    assign in_acc     = i_in_valid && !o_in_stall;
    assign freq_sum   = {1'b0, r_freq} + (FREQ_W + 1)'(r_spacing);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= '0;
            r_wsel <= 1'b0;
        end else if (in_acc) begin
            if (i_in_data.last_bin) begin
                r_freq <= '0;
                r_wsel <= !r_wsel;
            end else if (freq_sum[FREQ_W]) begin
                r_freq <= '1;
            end else begin
                r_freq <= freq_sum[FREQ_W-1:0];
            end
        end
    end

    // stage 1: locate region, issue reads
    logic                               r_p1_vld;
    logic [bbea_pkg::MAG_WIDTH-1:0]     r_p1_mag;
    logic                               r_p1_last;
    logic [FREQ_W-1:0]                  r_p1_freq;
    logic                               r_p1_copy;
    logic [bbea_pkg::NUM_EDGES-2:0]     ge;
    logic [bbea_pkg::REGION_WIDTH-1:0]  region;
    logic [IDX_W-1:0]                   idx_e;
    logic [IDX_W-1:0]                   idx_o;
    logic                               en_e;
    logic                               en_o;
    logic [ADDR_W-1:0]                  addr_e;
    logic [ADDR_W-1:0]                  addr_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else begin
            r_p1_vld <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p1_mag  <= i_in_data.bin_magnitude;
            r_p1_last <= i_in_data.last_bin;
            r_p1_freq <= r_freq;
            r_p1_copy <= r_wsel;
        end
    end

    always_comb begin
        for (int e = 1; e < bbea_pkg::NUM_EDGES; e++) begin
            ge[e-1] = r_p1_freq >= FREQ_W'(bbea_pkg::EDGE_HZ[e]);
        end
    end

    assign region = bbea_pkg::REGION_WIDTH'($countones(ge));
    assign idx_e  = region[IDX_W:1];
    assign idx_o  = region[0] ? region[IDX_W:1] : region[IDX_W:1] - IDX_W'(1);
    assign en_e   = r_p1_vld && (region <= bbea_pkg::REGION_WIDTH'(bbea_pkg::NUM_BANDS - 1));
    assign en_o   = r_p1_vld && (region != '0)
                    && (region <= bbea_pkg::REGION_WIDTH'(bbea_pkg::NUM_BANDS));
    assign addr_e = {r_p1_copy, idx_e};
    assign addr_o = {r_p1_copy, idx_o};

    // band memories and valid bits
    logic [SUM_W-1:0]      r_mem_even [BANK_DEPTH];
    logic [SUM_W-1:0]      r_mem_odd  [BANK_DEPTH];
    logic [BANK_DEPTH-1:0] r_vld_e;
    logic [BANK_DEPTH-1:0] r_vld_o;
    logic [BANK_DEPTH-1:0] n_vld_e;
    logic [BANK_DEPTH-1:0] n_vld_o;
    logic [SUM_W-1:0]      r_acc_rd_e;
    logic [SUM_W-1:0]      r_acc_rd_o;
    logic                  r_acc_rv_e;
    logic                  r_acc_rv_o;

    always_ff @(posedge i_clk) begin
        r_acc_rd_e <= r_mem_even[addr_e];
        r_acc_rd_o <= r_mem_odd[addr_o];
        r_acc_rv_e <= r_vld_e[addr_e];
        r_acc_rv_o <= r_vld_o[addr_o];
    end

    // stage 2: add and write back
    logic                           r_p2_vld;
    logic                           r_p2_en_e;
    logic                           r_p2_en_o;
    logic                           r_p2_last;
    logic                           r_p2_copy;
    logic [ADDR_W-1:0]              r_p2_addr_e;
    logic [ADDR_W-1:0]              r_p2_addr_o;
    logic [bbea_pkg::MAG_WIDTH-1:0] r_p2_mag;
    logic                           r_fw_e_vld;
    logic                           r_fw_o_vld;
    logic [ADDR_W-1:0]              r_fw_e_addr;
    logic [ADDR_W-1:0]              r_fw_o_addr;
    logic [SUM_W-1:0]               r_fw_e_data;
    logic [SUM_W-1:0]               r_fw_o_data;
    logic [SUM_W-1:0]               old_e;
    logic [SUM_W-1:0]               old_o;
    logic [SUM_W:0]                 sum_e;
    logic [SUM_W:0]                 sum_o;
    logic [SUM_W-1:0]               new_e;
    logic [SUM_W-1:0]               new_o;
    logic                           wr_e;
    logic                           wr_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld   <= 1'b0;
            r_p2_en_e  <= 1'b0;
            r_p2_en_o  <= 1'b0;
            r_fw_e_vld <= 1'b0;
            r_fw_o_vld <= 1'b0;
        end else begin
            r_p2_vld   <= r_p1_vld;
            r_p2_en_e  <= en_e;
            r_p2_en_o  <= en_o;
            r_fw_e_vld <= wr_e;
            r_fw_o_vld <= wr_o;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2_last   <= r_p1_last;
        r_p2_copy   <= r_p1_copy;
        r_p2_addr_e <= addr_e;
        r_p2_addr_o <= addr_o;
        r_p2_mag    <= r_p1_mag;
        r_fw_e_addr <= r_p2_addr_e;
        r_fw_o_addr <= r_p2_addr_o;
        r_fw_e_data <= new_e;
        r_fw_o_data <= new_o;
    end

    assign old_e = (r_fw_e_vld && (r_fw_e_addr == r_p2_addr_e)) ? r_fw_e_data :
                   (r_acc_rv_e ? r_acc_rd_e : '0);
    assign old_o = (r_fw_o_vld && (r_fw_o_addr == r_p2_addr_o)) ? r_fw_o_data :
                   (r_acc_rv_o ? r_acc_rd_o : '0);
    assign sum_e = {1'b0, old_e} + (SUM_W + 1)'(r_p2_mag);
    assign sum_o = {1'b0, old_o} + (SUM_W + 1)'(r_p2_mag);
    assign new_e = sum_e[SUM_W] ? '1 : sum_e[SUM_W-1:0];
    assign new_o = sum_o[SUM_W] ? '1 : sum_o[SUM_W-1:0];
    assign wr_e  = r_p2_vld && r_p2_en_e;
    assign wr_o  = r_p2_vld && r_p2_en_o;

    always_ff @(posedge i_clk) begin
        if (wr_e) begin
            r_mem_even[r_p2_addr_e] <= new_e;
        end
        if (wr_o) begin
            r_mem_odd[r_p2_addr_o] <= new_o;
        end
    end

    // drain control
    logic                             r_dact;
    logic                             r_dsel;
    logic [bbea_pkg::BAND_WIDTH-1:0]  r_dcnt;
    logic                             d_adv;
    logic                             d_start;
    logic                             d_issue;
    logic                             d_done;
    logic [ADDR_W-1:0]                d_addr;
    logic                             r_out_vld;

    assign d_adv   = !(r_out_vld && i_out_stall);
    assign d_start = !r_dact && r_req[r_dsel];
    assign d_issue = r_dact && d_adv;
    assign d_done  = d_issue && (r_dcnt == bbea_pkg::LAST_BAND_INDEX);
    assign d_addr  = {r_dsel, r_dcnt[IDX_W:1]};

    always_comb begin
        logic [ADDR_W-1:0] av;
        n_vld_e = r_vld_e;
        n_vld_o = r_vld_o;
        av      = '0;
        if (wr_e) begin
            n_vld_e[r_p2_addr_e] = 1'b1;
        end
        if (wr_o) begin
            n_vld_o[r_p2_addr_o] = 1'b1;
        end
        for (int a = 0; a < BANK_DEPTH; a++) begin
            av = ADDR_W'(a);
            if (d_done && (av[ADDR_W-1] == r_dsel)) begin
                n_vld_e[a] = 1'b0;
                n_vld_o[a] = 1'b0;
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_req  = r_req;
        if (d_done) begin
            n_busy[r_dsel] = 1'b0;
        end
        if (in_acc && i_in_data.last_bin) begin
            n_busy[r_wsel] = 1'b1;
        end
        if (d_start) begin
            n_req[r_dsel] = 1'b0;
        end
        if (r_p2_vld && r_p2_last) begin
            n_req[r_p2_copy] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_e <= '0;
            r_vld_o <= '0;
            r_busy  <= '0;
            r_req   <= '0;
            r_dact  <= 1'b0;
            r_dsel  <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            r_vld_e <= n_vld_e;
            r_vld_o <= n_vld_o;
            r_busy  <= n_busy;
            r_req   <= n_req;
            if (d_start) begin
                r_dact <= 1'b1;
                r_dcnt <= '0;
            end else if (d_done) begin
                r_dact <= 1'b0;
                r_dsel <= !r_dsel;
            end else if (d_issue) begin
                r_dcnt <= r_dcnt + 1'b1;
            end
        end
    end

    // drain path: read, weigh, output
    logic [SUM_W-1:0]                   r_dr_e;
    logic [SUM_W-1:0]                   r_dr_o;
    logic                               r_dr_ve;
    logic                               r_dr_vo;
    logic                               r_d1_vld;
    logic [bbea_pkg::BAND_WIDTH-1:0]    r_d1_band;
    logic                               r_d2_vld;
    logic [bbea_pkg::BAND_WIDTH-1:0]    r_d2_band;
    logic [PROD_W-1:0]                  r_d2_prod;
    logic [SUM_W-1:0]                   raw;
    logic [bbea_pkg::WEIGHT_WIDTH-1:0]  weight;
    bbea_pkg::t_out_word                r_out_data;

    always_ff @(posedge i_clk) begin
        if (d_adv) begin
            r_dr_e    <= r_mem_even[d_addr];
            r_dr_o    <= r_mem_odd[d_addr];
            r_dr_ve   <= r_vld_e[d_addr];
            r_dr_vo   <= r_vld_o[d_addr];
        end
    end

    assign raw    = r_d1_band[0] ? (r_dr_vo ? r_dr_o : '0) : (r_dr_ve ? r_dr_e : '0);
    assign weight = bbea_pkg::LOUD_Q16[r_d1_band];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_vld  <= 1'b0;
            r_d2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (d_adv) begin
            r_d1_vld  <= d_issue;
            r_d2_vld  <= r_d1_vld;
            r_out_vld <= r_d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_adv) begin
            r_d1_band              <= r_dcnt;
            r_d2_band              <= r_d1_band;
            r_d2_prod              <= PROD_W'(raw) * PROD_W'(weight);
            r_out_data.band_index  <= r_d2_band;
            r_out_data.band_energy <= r_d2_prod[PROD_W-1:bbea_pkg::WEIGHT_WIDTH];
            r_out_data.last_band   <= (r_d2_band == bbea_pkg::LAST_BAND_INDEX);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

@@ src/bbea_checker.sv @@
// Port-level checker for the bark band energy accumulator, bound to the top level
`timescale 1ns / 1ps
`include "bark_band_energy_accumulator_macros.svh"

module bbea_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [bbea_pkg::PADDR_WIDTH-1:0] paddr,
    input logic [bbea_pkg::PDATA_WIDTH-1:0] pwdata,
    input logic [bbea_pkg::PDATA_WIDTH-1:0] prdata,
    input logic                             o_out_valid,
    input bbea_pkg::t_out_word              o_out_data,
    input logic                             i_out_stall
);

    `BBEA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `BBEA_ASSERT_NOW(a_last_band, i_clk, i_rst_n, o_out_valid, o_out_data.last_band == (o_out_data.band_index == bbea_pkg::LAST_BAND_INDEX))
    `BBEA_ASSERT_NEXT(a_cfg_readback, i_clk, i_rst_n, psel && penable && pwrite && (paddr[bbea_pkg::PADDR_WIDTH-1] == bbea_pkg::REG_BIN_SPACING), (paddr[bbea_pkg::PADDR_WIDTH-1] != bbea_pkg::REG_BIN_SPACING) || (prdata[bbea_pkg::SPACING_WIDTH-1:0] == $past(pwdata[bbea_pkg::SPACING_WIDTH-1:0])))

endmodule

bind bark_band_energy_accumulator bbea_checker u_bbea_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

@@ dv/bark_band_energy_accumulator_tb.sv @@
// Self-checking testbench for the Bark band energy accumulator: predicts weighted band sums per frame
`timescale 1ns / 1ps

module bark_band_energy_accumulator_tb;
    import bbea_pkg::*;

    localparam logic [PADDR_WIDTH-1:0] ADDR_BIN_SPACING = {REG_BIN_SPACING, 2'b00};
    localparam logic [PADDR_WIDTH-1:0] ADDR_UNMAPPED    = 3'd4;
    localparam logic [SUM_WIDTH-1:0]   SUM_LIMIT        = '1;
    localparam logic [FREQ_WIDTH-1:0]  FREQ_LIMIT       = '1;
    localparam logic [ENERGY_WIDTH-1:0] ENERGY_LIMIT    = '1;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_WIDTH-1:0] paddr = '0;
    logic [PDATA_WIDTH-1:0] pwdata = '0;
    logic [PDATA_WIDTH-1:0] prdata;
    logic                   pready;
    logic                   i_in_valid = 1'b0;
    t_in_word               i_in_data = '0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    t_out_word              o_out_data;
    logic                   i_out_stall = 1'b0;

    bark_band_energy_accumulator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [SPACING_WIDTH-1:0] spacing_shadow = SPACING_RESET;
    logic [FREQ_WIDTH-1:0]    freq_shadow = '0;
    logic [SUM_WIDTH-1:0]     band_sum_shadow [NUM_BANDS];
    t_out_word                pending_bands [$];

    int  error_count = 0;
    int  bins_sent = 0;
    int  frames_sent = 0;
    int  words_checked = 0;
    int  input_stall_cycles = 0;
    bit  gaps_on = 1'b0;
    bit  stalls_on = 1'b0;
    int  hold_request = 0;
    int  stall_left = 0;

    initial begin
        for (int b = 0; b < NUM_BANDS; b++) band_sum_shadow[b] = '0;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [MAG_WIDTH-1:0] rand_mag();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return '0;
            2: return MAG_WIDTH'($urandom_range(0, 255));
            default: return MAG_WIDTH'($urandom);
        endcase
    endfunction

    task automatic add_to_band(input int b, input logic [MAG_WIDTH-1:0] mag);
        if (band_sum_shadow[b] > SUM_LIMIT - mag) begin
            band_sum_shadow[b] = SUM_LIMIT;
        end else begin
            band_sum_shadow[b] = band_sum_shadow[b] + mag;
        end
    endtask

    task automatic predict_bin(input logic [MAG_WIDTH-1:0] mag, input logic last);
        int        region;
        logic [FREQ_WIDTH:0] next_freq;
        logic [63:0] sum64;
        logic [63:0] energy;
        t_out_word   word;
        region = 0;
        while (region < TOP_REGION && freq_shadow >= FREQ_WIDTH'(EDGE_HZ[region + 1])) begin
            region++;
        end
        if (region < TOP_REGION) begin
            if (region >= 1) add_to_band(region - 1, mag);
            if (region < NUM_BANDS) add_to_band(region, mag);
        end
        next_freq = freq_shadow + spacing_shadow;
        if (next_freq > {1'b0, FREQ_LIMIT}) begin
            freq_shadow = FREQ_LIMIT;
        end else begin
            freq_shadow = next_freq[FREQ_WIDTH-1:0];
        end
        if (last) begin
            for (int b = 0; b < NUM_BANDS; b++) begin
                sum64 = 64'(band_sum_shadow[b]);
                energy = (sum64 >> 16) * 64'(LOUD_Q16[b])
                       + (((sum64 & 64'hFFFF) * 64'(LOUD_Q16[b])) >> 16);
                if (energy > 64'(ENERGY_LIMIT)) energy = 64'(ENERGY_LIMIT);
                word.band_index  = BAND_WIDTH'(b);
                word.band_energy = energy[ENERGY_WIDTH-1:0];
                word.last_band   = (BAND_WIDTH'(b) == LAST_BAND_INDEX);
                pending_bands.push_back(word);
                band_sum_shadow[b] = '0;
            end
            freq_shadow = '0;
            frames_sent++;
        end
        bins_sent++;
    endtask

    task automatic send_bin(input logic [MAG_WIDTH-1:0] mag, input logic last);
        int       gap;
        t_in_word word;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word.bin_magnitude = mag;
        word.last_bin      = last;
        i_in_valid <= 1'b1;
        i_in_data  <= word;
        @(posedge i_clk);
        while (o_in_stall) begin
            input_stall_cycles++;
            @(posedge i_clk);
        end
        predict_bin(mag, last);
    endtask

    task automatic drain_frames();
        i_in_valid <= 1'b0;
        while (pending_bands.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_WIDTH-1:0] addr, input logic [PDATA_WIDTH-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_BIN_SPACING) spacing_shadow = data[SPACING_WIDTH-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_check_spacing();
        logic [PDATA_WIDTH-1:0] want;
        want = PDATA_WIDTH'(spacing_shadow);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_BIN_SPACING;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want) begin
            $error("bin_spacing_hz: expected %0d, got %0d", want, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_spacing(input logic [PDATA_WIDTH-1:0] data);
        apb_write(ADDR_BIN_SPACING, data);
        apb_check_spacing();
    endtask

    task automatic check_band_word(input t_out_word got);
        t_out_word want;
        if (pending_bands.size() == 0) begin
            $error("band word with none pending: band_index %0d band_energy %0d",
                   got.band_index, got.band_energy);
            error_count++;
        end else begin
            want = pending_bands.pop_front();
            words_checked++;
            if (got.band_index !== want.band_index) begin
                $error("band_index: expected %0d, got %0d", want.band_index, got.band_index);
                error_count++;
            end
            if (got.band_energy !== want.band_energy) begin
                $error("band_energy: expected %0d, got %0d", want.band_energy, got.band_energy);
                error_count++;
            end
            if (got.last_band !== want.last_band) begin
                $error("last_band: expected %0b, got %0b", want.last_band, got.last_band);
                error_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_band_word(o_out_data);
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (hold_request > 0) begin
            stall_left = hold_request - 1;
            hold_request = 0;
            i_out_stall <= 1'b1;
        end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left = idle_len() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic test_reset_spacing();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        apb_check_spacing();
        send_bin('1, 1'b0);
        send_bin('0, 1'b0);
        send_bin(24'hAAAAAA, 1'b0);
        send_bin(24'h555555, 1'b0);
        send_bin('1, 1'b1);
        drain_frames();
    endtask

    task automatic test_band_boundaries();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        set_spacing(32'd50);
        for (int n = 0; n < 5; n++) send_bin('1, n == 4);
        drain_frames();
        set_spacing(32'd4500);
        for (int n = 0; n < 4; n++) send_bin(24'hFFFFFF - n, n == 3);
        drain_frames();
        set_spacing(32'd7750);
        for (int n = 0; n < 3; n++) send_bin(24'h800001, n == 2);
        drain_frames();
        set_spacing(32'd24000);
        send_bin('1, 1'b0);
        send_bin('1, 1'b1);
        send_bin(24'h123456, 1'b1);
        drain_frames();
    endtask

    task automatic test_unmapped_write();
        apb_write(ADDR_UNMAPPED, 32'h0000_0001);
        apb_check_spacing();
        send_bin(24'h00F00F, 1'b0);
        send_bin(24'hFF0FF0, 1'b1);
        drain_frames();
    endtask

    task automatic test_freq_saturation();
        gaps_on = 1'b0;
        stalls_on = 1'b1;
        set_spacing(32'hFFFF_FFFF);
        for (int n = 0; n < 520; n++) send_bin(rand_mag(), n == 519);
        drain_frames();
    endtask

    task automatic test_sum_saturation();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        set_spacing(32'h0000_8000);
        for (int n = 0; n < 65540; n++) send_bin('1, n == 65539);
        drain_frames();
    endtask

    task automatic test_random_frames();
        int filled;
        int len;
        for (int phase = 0; phase < 6; phase++) begin
            gaps_on = (phase % 3) != 0;
            stalls_on = (phase % 2) != 0;
            case (phase)
                0: set_spacing(32'd1);
                1: set_spacing(32'd24000);
                default: begin
                    if ($urandom_range(0, 1) == 0) set_spacing(32'($urandom_range(200, 1200)));
                    else set_spacing(32'($urandom_range(1, 24000)));
                end
            endcase
            filled = 0;
            while (filled < 30) begin
                len = $urandom_range(1, 40);
                for (int n = 0; n < len; n++) send_bin(rand_mag(), n == len - 1);
                filled += len;
            end
            drain_frames();
        end
    endtask

    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        set_spacing(32'd43);
        hold_request = 400;
        for (int f = 0; f < 16; f++) begin
            send_bin(rand_mag(), 1'b0);
            send_bin(rand_mag(), 1'b1);
        end
        drain_frames();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_spacing();
        test_band_boundaries();
        test_unmapped_write();
        test_freq_saturation();
        test_sum_saturation();
        test_random_frames();
        test_output_backpressure();
        repeat (40) @(posedge i_clk);
        $display("covered %0d bins in %0d frames, %0d band words checked",
                 bins_sent, frames_sent, words_checked);
        $display("spacings 0 to 32767, both saturations, %0d input stall cycles seen",
                 input_stall_cycles);
        if (error_count == 0) begin
            $display("bark_band_energy_accumulator_tb: clean");
        end else begin
            $display("bark_band_energy_accumulator_tb: errors");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("bark_band_energy_accumulator_tb: errors");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/bbea_pkg.sv
src/bark_band_energy_accumulator.sv
src/bbea_checker.sv
dv/bark_band_energy_accumulator_tb.sv
